>>> rtl/core/lkw_pkg.sv
// Shared types and constants of the link keepalive watchdog.
// Used by lkw_interval, lkw_engine and link_keepalive_watchdog; depends on nothing.
package lkw_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned IDX_IN_W = 4;
  localparam int unsigned RTT_W    = 20;
  localparam int unsigned EST_W    = 24;
  localparam int unsigned KA_W     = 19;  // keepalive interval, up to 360000
  localparam int unsigned LIM_W    = 23;  // 4*rtt + grace

  localparam logic [KA_W-1:0]  KA_MIN_MS = 19'd5000;
  localparam logic [KA_W-1:0]  KA_MAX_MS = 19'd360000;
  localparam logic [LIM_W-1:0] GRACE_MS  = 23'd5000;

  // rtt*1440/7 == rtt*205 + floor(rtt*5/7)
  localparam logic [KA_W-1:0] KA_BASE_MUL = 19'd205;
  localparam logic [13:0]     KA_FRAC_MUL = 14'd5;
  localparam logic [27:0]     RECIP7      = 28'd9363;  // ceil(2^16/7)

  // rtt at or above this saturates at the maximum interval
  localparam logic [RTT_W-1:0] RTT_SAT_HI = 20'd1750;
  // rtt at or below this gives the minimum interval
  localparam logic [RTT_W-1:0] RTT_SAT_LO = 20'd24;

  typedef enum logic [1:0] {
    ACT_ACTIVATE = 2'd0,
    ACT_CHECK    = 2'd1,
    ACT_PENDING  = 2'd2,
    ACT_RELEASE  = 2'd3
  } lkw_action_t;

  // Request as held in the input register
  typedef struct packed {
    lkw_action_t          action;
    logic [IDX_IN_W-1:0]  link_index;
    logic [TIME_W-1:0]    now_ms;
    logic [TIME_W-1:0]    last_inbound_ms;
    logic                 is_initiator;
    logic                 link_active;
    logic                 pend_expired;
    logic [KA_W-1:0]      ka_ms;
    logic [LIM_W-1:0]     stale_lim;
  } lkw_req_t;

  typedef struct packed {
    logic link_stale;
    logic tear_down;
    logic ka_due;
  } lkw_res_t;

endpackage

>>> rtl/core/lkw_interval.sv
// Keepalive interval and stale timeout limit derived from the round trip time.
// Depends on lkw_pkg.
module lkw_interval (
  input  logic [lkw_pkg::RTT_W-1:0] rtt_ms,
  output logic [lkw_pkg::KA_W-1:0]  ka_ms,
  output logic [lkw_pkg::LIM_W-1:0] stale_lim
);
  import lkw_pkg::*;

  logic [10:0]     rtt_lo;
  logic [KA_W-1:0] base;
  logic [13:0]     five_r;
  logic [27:0]     prod;
  logic [KA_W-1:0] ka_mid;

  // rtt*205 + floor(5*rtt/7), exact in the unsaturated range
  assign rtt_lo = rtt_ms[10:0];
  assign base   = {8'd0, rtt_lo} * KA_BASE_MUL;
  assign five_r = {3'd0, rtt_lo} * KA_FRAC_MUL;
  assign prod   = {14'd0, five_r} * RECIP7;
  assign ka_mid = base + {8'd0, prod[26:16]};

  // Clamp to the interval range
  always_comb begin
    if (rtt_ms >= RTT_SAT_HI) begin
      ka_ms = KA_MAX_MS;
    end else if (rtt_ms <= RTT_SAT_LO) begin
      ka_ms = KA_MIN_MS;
    end else begin
      ka_ms = ka_mid;
    end
  end

  assign stale_lim = {1'b0, rtt_ms, 2'b00} + GRACE_MS;

endmodule

>>> rtl/core/lkw_engine.sv
// Link table and per-request evaluation: reads the addressed entry, forms the
// result and writes the entry back in the same cycle. Depends on lkw_pkg.
module lkw_engine #(
  parameter int LINK_COUNT = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              proc,
  input  lkw_pkg::lkw_req_t req,
  output lkw_pkg::lkw_res_t res
);
  import lkw_pkg::*;

  localparam int IDX_W = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

  logic [TIME_W-1:0] act_r [LINK_COUNT];
  logic [TIME_W-1:0] kas_r [LINK_COUNT];
  logic [TIME_W-1:0] sst_r [LINK_COUNT];
  logic              smk_r [LINK_COUNT];
  logic [LINK_COUNT-1:0] vld_r;

  logic [8:0]        idx_ext;
  logic [IDX_W-1:0]  sel;
  logic              hit;
  logic              e_vld;
  logic [TIME_W-1:0] e_act, e_kas, e_sst;
  logic              e_smk;

  logic [TIME_W-1:0] last;
  logic [TIME_W:0]   now_w, last_k, last_2k, kas_k, sst_lim;
  logic              ka_fire;

  logic [TIME_W-1:0] act_nxt, kas_nxt, sst_nxt;
  logic              smk_nxt, vld_nxt;

  // Decode the entry; an invalid entry reads as cleared
  assign idx_ext = {5'd0, req.link_index};
  assign sel     = idx_ext[IDX_W-1:0];
  assign hit     = idx_ext < 9'(LINK_COUNT);
  assign e_vld   = hit && vld_r[sel];
  assign e_act   = e_vld ? act_r[sel] : '0;
  assign e_kas   = e_vld ? kas_r[sel] : '0;
  assign e_sst   = e_vld ? sst_r[sel] : '0;
  assign e_smk   = e_vld ? smk_r[sel] : 1'b0;

  // Deadlines, one bit wider so nothing wraps
  assign last    = (req.last_inbound_ms > e_act) ? req.last_inbound_ms : e_act;
  assign now_w   = {1'b0, req.now_ms};
  assign last_k  = {1'b0, last} + {30'd0, req.ka_ms};
  assign last_2k = {1'b0, last} + {29'd0, req.ka_ms, 1'b0};
  assign kas_k   = {1'b0, e_kas} + {30'd0, req.ka_ms};
  assign sst_lim = {1'b0, e_sst} + {26'd0, req.stale_lim};
  assign ka_fire = req.is_initiator && (now_w >= last_k) && (now_w >= kas_k);

  // Evaluate the request and the entry's next contents
  always_comb begin
    act_nxt = e_act;
    kas_nxt = e_kas;
    sst_nxt = e_sst;
    smk_nxt = e_smk;
    vld_nxt = e_vld;
    res     = '0;
    case (req.action)
      ACT_ACTIVATE: begin
        act_nxt = req.now_ms;
        kas_nxt = '0;
        sst_nxt = '0;
        smk_nxt = 1'b0;
        vld_nxt = 1'b1;
      end
      ACT_RELEASE: begin
        vld_nxt = 1'b0;
      end
      ACT_PENDING: begin
        if (req.pend_expired) begin
          vld_nxt       = 1'b0;
          res.tear_down = 1'b1;
        end else begin
          res.link_stale = e_smk;
        end
      end
      ACT_CHECK: begin
        if (req.link_active) begin
          vld_nxt = 1'b1;
          if (ka_fire) begin
            kas_nxt    = req.now_ms;
            res.ka_due = 1'b1;
          end
          if (now_w < last_2k) begin
            smk_nxt = 1'b0;
            sst_nxt = '0;
          end else if (!e_smk) begin
            smk_nxt = 1'b1;
            sst_nxt = req.now_ms;
          end else if (now_w >= sst_lim) begin
            vld_nxt       = 1'b0;
            smk_nxt       = 1'b0;
            res.tear_down = 1'b1;
          end
        end
        res.link_stale = smk_nxt;
      end
      default: begin
        res = '0;
      end
    endcase
    if (!hit) begin
      res = '0;
    end
  end

  // Clear valid bits under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (proc && hit) begin
      vld_r[sel] <= vld_nxt;
    end
  end

  // Write back the addressed entry
  always_ff @(posedge clk) begin
    if (proc && hit) begin
      act_r[sel] <= act_nxt;
      kas_r[sel] <= kas_nxt;
      sst_r[sel] <= sst_nxt;
      smk_r[sel] <= smk_nxt;
    end
  end

endmodule

>>> rtl/core/link_keepalive_watchdog.sv
// Link keepalive watchdog, top level: input register, link table engine and
// result register. Depends on lkw_pkg, lkw_interval and lkw_engine.
//
// One request per clock cycle as long as out_tready stays high, one result per
// request. A request waits in the input register, where the keepalive interval
// and the pending-deadline compare are already formed, until the result register
// can take a new result; the link table is then read and written in the same
// cycle as the result is captured in the output register, so back-to-back
// requests on one link see each other's updates. Request kinds: activate, check
// active link, check pending link, release. No configuration, no clearing pass.
module link_keepalive_watchdog #(
  parameter int LINK_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [3:0] link_index, [51:4] now_ms, [71:52] rtt_ms, [119:72] last_inbound_ms,
  // [120] is_initiator, [121] link_active, [122] link_pending,
  // [170:123] request_time_ms, [194:171] establishment_timeout_ms, rest zero
  input  logic [199:0] in_tdata,
  // [1:0] action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [0] ka_due, [1] tear_down, [2] link_stale, rest zero
  output logic [7:0]   out_tdata
);
  import lkw_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  lkw_req_t          req_r, req_nxt;
  logic              out_vld_r, out_vld_nxt;
  lkw_res_t          res_r;
  lkw_res_t          res;
  logic              out_free, proc, in_acc;

  logic [TIME_W-1:0] f_now, f_inb, f_req;
  logic [RTT_W-1:0]  f_rtt;
  logic [EST_W-1:0]  f_est;
  logic [KA_W-1:0]   ka_ms;
  logic [LIM_W-1:0]  stale_lim;

  // Unpack the request
  assign f_now = in_tdata[51:4];
  assign f_rtt = in_tdata[71:52];
  assign f_inb = in_tdata[119:72];
  assign f_req = in_tdata[170:123];
  assign f_est = in_tdata[194:171];

  lkw_interval u_interval (
    .rtt_ms    (f_rtt),
    .ka_ms     (ka_ms),
    .stale_lim (stale_lim)
  );

  always_comb begin
    req_nxt                 = req_r;
    req_nxt.action          = lkw_action_t'(in_tuser);
    req_nxt.link_index      = in_tdata[3:0];
    req_nxt.now_ms          = f_now;
    req_nxt.last_inbound_ms = f_inb;
    req_nxt.is_initiator    = in_tdata[120];
    req_nxt.link_active     = in_tdata[121];
    req_nxt.pend_expired    = in_tdata[122] &&
                              ({1'b0, f_now} >= ({1'b0, f_req} + {25'd0, f_est}));
    req_nxt.ka_ms           = ka_ms;
    req_nxt.stale_lim       = stale_lim;
  end

  // Handshake: advance when the result register can take a new result
  assign out_free    = !out_vld_r || out_tready;
  assign proc        = in_vld_r && out_free;
  assign in_tready   = !in_vld_r || out_free;
  assign in_acc      = in_tvalid && in_tready;
  assign in_vld_nxt  = in_acc ? 1'b1 : (proc ? 1'b0 : in_vld_r);
  assign out_vld_nxt = proc ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  lkw_engine #(
    .LINK_COUNT (LINK_COUNT)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (proc),
    .req   (req_r),
    .res   (res)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= req_nxt;
    end
    if (proc) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, res_r.link_stale, res_r.tear_down, res_r.ka_due};

`ifndef SYNTH
  // A new result only appears after a request was evaluated
  a_res_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(proc))
    else $error("result appeared without an evaluated request");

  // Activate and release always give an all-zero result
  a_act_rel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && (req_r.action == ACT_ACTIVATE || req_r.action == ACT_RELEASE))
      |=> (out_tdata[2:0] == 3'd0))
    else $error("activate or release gave a nonzero result");

  // A torn-down link is never reported stale
  a_to_not_stale: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> !out_tdata[2])
    else $error("tear_down reported with link_stale set");

  // A held request blocks new input while the result register is stuck
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input accepted while request register is blocked");
`endif

endmodule

>>> tb/tb.sv
// Testbench for link_keepalive_watchdog: directed and random requests on the stream ports,
// with a scoreboard that predicts each verdict. Depends on lkw_pkg and the watchdog RTL.
`timescale 1ns / 1ps

module tb;
  import lkw_pkg::*;

  localparam int NUM_LINKS = 16;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  // One request as the sender sees it
  typedef struct {
    lkw_action_t  action;
    logic [3:0]   link;
    logic [47:0]  now;
    logic [19:0]  rtt;
    logic [47:0]  inbound;
    bit           initiator;
    bit           active;
    bit           pending;
    logic [47:0]  req_time;
    logic [23:0]  est;
  } link_req_t;

  // Scoreboard: predicts one verdict per request and checks verdicts in order
  class keepalive_scoreboard;
    logic [47:0] activated_at [NUM_LINKS];
    logic [47:0] keepalive_at [NUM_LINKS];
    logic [47:0] stale_from [NUM_LINKS];
    bit          stale [NUM_LINKS];
    lkw_res_t    expected_verdicts [$];
    int          errors;

    function new();
      for (int i = 0; i < NUM_LINKS; i++) clear_link(i);
      errors = 0;
    endfunction

    function void clear_link(int i);
      activated_at[i] = '0;
      keepalive_at[i] = '0;
      stale_from[i] = '0;
      stale[i] = 1'b0;
    endfunction

    function int outstanding();
      return expected_verdicts.size();
    endfunction

    // Predict the verdict of an accepted request and advance the link table
    function void note_request(link_req_t r);
      lkw_res_t v;
      logic [63:0] now64, rtt64, ka, last, deadline;
      int i;
      v = '0;
      i = int'(r.link);
      now64 = 64'(r.now);
      rtt64 = 64'(r.rtt);
      case (r.action)
        ACT_ACTIVATE: begin
          clear_link(i);
          activated_at[i] = r.now;
        end
        ACT_RELEASE: clear_link(i);
        ACT_PENDING: begin
          deadline = 64'(r.req_time) + 64'(r.est);
          if (r.pending && now64 >= deadline) begin
            v.tear_down = 1'b1;
            clear_link(i);
          end
          v.link_stale = stale[i];
        end
        default: begin
          if (r.active) begin
            // interval: rtt * 360 / 1.75, clamped
            ka = rtt64 * 64'd1440 / 64'd7;
            if (ka > 64'(KA_MAX_MS)) ka = 64'(KA_MAX_MS);
            if (ka < 64'(KA_MIN_MS)) ka = 64'(KA_MIN_MS);
            last = (r.inbound > activated_at[i]) ? 64'(r.inbound) : 64'(activated_at[i]);
            if (r.initiator && now64 >= last + ka && now64 >= 64'(keepalive_at[i]) + ka) begin
              v.ka_due = 1'b1;
              keepalive_at[i] = r.now;
            end
            if (now64 < last + 64'd2 * ka) begin
              stale[i] = 1'b0;
              stale_from[i] = '0;
            end else if (!stale[i]) begin
              stale[i] = 1'b1;
              stale_from[i] = r.now;
            end else if (now64 >= 64'(stale_from[i]) + 64'd4 * rtt64 + 64'(GRACE_MS)) begin
              v.tear_down = 1'b1;
              clear_link(i);
            end
          end
          v.link_stale = stale[i];
        end
      endcase
      expected_verdicts.insert(expected_verdicts.size(), v);
    endfunction

    function void report(string field, logic [4:0] exp_v, logic [4:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t ns: %s expected %0h actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    // Compare one accepted verdict with the oldest prediction
    function void check_verdict(logic [7:0] data);
      lkw_res_t v;
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t ns: verdict with none expected, expected none actual %0h", $time, data);
        return;
      end
      v = expected_verdicts[0];
      expected_verdicts.delete(0);
      report("ka_due", 5'(v.ka_due), 5'(data[0]));
      report("tear_down", 5'(v.tear_down), 5'(data[1]));
      report("link_stale", 5'(v.link_stale), 5'(data[2]));
      report("padding", 5'd0, data[7:3]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;

  keepalive_scoreboard board = new();
  bit calm = 1'b0;

  // Per-link stimulus timeline so that checks walk through the watchdog phases
  logic [47:0] link_clock [NUM_LINKS];
  logic [47:0] link_inbound [NUM_LINKS];
  logic [19:0] link_rtt [NUM_LINKS];

  link_keepalive_watchdog dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up long after the slowest correct run
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic logic [19:0] pick_rtt();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 6) return 20'($urandom_range(0, 2000));
    if (roll < 9) return 20'($urandom_range(0, 40));
    return 20'($urandom_range(0, 20'hFFFFF));
  endfunction

  function automatic link_req_t make_request(lkw_action_t action, logic [3:0] link,
                                             logic [47:0] now, logic [19:0] rtt,
                                             logic [47:0] inbound, bit initiator, bit active,
                                             bit pending, logic [47:0] req_time,
                                             logic [23:0] est);
    link_req_t r;
    r.action = action;
    r.link = link;
    r.now = now;
    r.rtt = rtt;
    r.inbound = inbound;
    r.initiator = initiator;
    r.active = active;
    r.pending = pending;
    r.req_time = req_time;
    r.est = est;
    return r;
  endfunction

  // Build a random request: mostly well-formed link lifetimes, some pure noise
  function automatic link_req_t random_request();
    link_req_t r;
    logic [3:0] l;
    int unsigned sel, ka, lim, step;
    r = make_request(lkw_action_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     rand48(), 20'($urandom_range(0, 20'hFFFFF)), rand48(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), rand48(),
                     24'($urandom_range(0, 24'hFFFFFF)));
    sel = $urandom_range(0, 99);
    if (sel < 10) return r;

    l = 4'($urandom_range(0, 15));
    ka = link_rtt[l] * 1440 / 7;
    if (ka > 360000) ka = 360000;
    if (ka < 5000) ka = 5000;
    lim = 4 * link_rtt[l] + 5000;
    case ($urandom_range(0, 5))
      0: step = $urandom_range(0, 200);
      1: step = $urandom_range(0, ka / 2);
      2: step = ka - 2 + $urandom_range(0, 4);
      3: step = 2 * ka - 2 + $urandom_range(0, 4);
      4: step = lim - 2 + $urandom_range(0, 4);
      default: step = $urandom_range(ka, 3 * ka);
    endcase
    link_clock[l] = link_clock[l] + 48'(step);
    r.link = l;
    r.now = link_clock[l];
    if ($urandom_range(0, 9) != 0) r.rtt = link_rtt[l];

    if (sel < 18) begin
      r.action = ACT_ACTIVATE;
      link_rtt[l] = pick_rtt();
      link_inbound[l] = link_clock[l];
    end else if (sel < 72) begin
      r.action = ACT_CHECK;
      if ($urandom_range(0, 3) == 0) begin
        link_inbound[l] = link_clock[l] - 48'($urandom_range(0, 1000));
      end
      r.inbound = link_inbound[l];
      r.initiator = ($urandom_range(0, 3) != 0);
      r.active = ($urandom_range(0, 9) != 0);
    end else if (sel < 92) begin
      r.action = ACT_PENDING;
      r.est = 24'($urandom_range(0, 60000));
      r.req_time = link_clock[l] - 48'($urandom_range(0, 2 * r.est));
      r.pending = ($urandom_range(0, 4) != 0);
    end else begin
      r.action = ACT_RELEASE;
    end
    return r;
  endfunction

  // Present a request after a random gap and hold it until accepted
  task automatic send_request(link_req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.action;
    in_tdata <= {5'd0, r.est, r.req_time, r.pending, r.active, r.initiator, r.inbound,
                 r.rtt, r.now, r.link};
    do @(posedge clk); while (!in_tready);
    board.note_request(r);
  endtask

  // Hold the sender until every predicted verdict has come back
  task automatic drain_verdicts();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  // Check every verdict that the receiver takes
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_verdict(out_tdata);
  end

  // Receiver backpressure: ready runs broken by random stalls
  initial begin : ready_driver
    int unsigned gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_ACTIVATE;
    for (int i = 0; i < NUM_LINKS; i++) begin
      link_clock[i] = {8'd0, $urandom} + 48'd1_000_000;
      link_inbound[i] = link_clock[i];
      link_rtt[i] = pick_rtt();
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full keepalive and staleness walk on one link, rtt 100 ms
    send_request(make_request(ACT_ACTIVATE, 4'd1, 48'd1000, 20'd100, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd1, 48'd21571, 20'd100, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd1, 48'd21571, 20'd100, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd1, 48'd42142, 20'd100, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd1, 48'd47541, 20'd100, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd1, 48'd47542, 20'd100, 48'd0, 1, 1, 0, 0, 0));
    // Inactive link leaves the entry alone
    send_request(make_request(ACT_CHECK, 4'd1, MAX48, 20'd100, 48'd0, 1, 0, 0, 0, 0));
    // Pending deadline: one early, exactly due, not pending
    send_request(make_request(ACT_PENDING, 4'd2, 48'd1499, 0, 0, 0, 0, 1, 48'd1000, 24'd500));
    send_request(make_request(ACT_PENDING, 4'd2, 48'd1500, 0, 0, 0, 0, 1, 48'd1000, 24'd500));
    send_request(make_request(ACT_PENDING, 4'd2, MAX48, 0, 0, 0, 0, 0, 48'd0, 24'd0));
    // Sums at the top of the time range must not wrap
    send_request(make_request(ACT_PENDING, 4'd2, MAX48, 0, 0, 0, 0, 1, MAX48, 24'hFFFFFF));
    send_request(make_request(ACT_ACTIVATE, 4'd3, MAX48, 20'hFFFFF, MAX48, 1, 1, 1, MAX48, 0));
    send_request(make_request(ACT_CHECK, 4'd3, MAX48, 20'hFFFFF, MAX48, 1, 1, 1, MAX48,
                              24'hFFFFFF));
    // Interval clamp edges
    send_request(make_request(ACT_CHECK, 4'd4, 48'd5000, 20'd0, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd5, 48'd5000, 20'd24, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd6, 48'd5142, 20'd25, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd7, 48'd359794, 20'd1749, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd8, 48'd360000, 20'd1750, 48'd0, 1, 1, 0, 0, 0));
    // A keepalive stamped in the future blocks the next one
    send_request(make_request(ACT_ACTIVATE, 4'd9, 48'd0, 20'd0, 48'd0, 0, 0, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd9, 48'd1000000, 20'd0, 48'd995000, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd9, 48'd10000, 20'd0, 48'd0, 1, 1, 0, 0, 0));
    send_request(make_request(ACT_RELEASE, 4'd9, 48'd10000, 20'd0, 48'd0, 1, 1, 1, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd9, 48'd10000, 20'd0, 48'd0, 1, 1, 0, 0, 0));
    // Last entry, responder side
    send_request(make_request(ACT_ACTIVATE, 4'd15, 48'd7, 20'd10, 48'd0, 0, 1, 0, 0, 0));
    send_request(make_request(ACT_CHECK, 4'd15, 48'd20000, 20'd10, 48'd0, 0, 1, 0, 0, 0));
    drain_verdicts();

    // Random traffic, with calm stretches and one mid-run drain
    for (n = 0; n < 1500; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 750) drain_verdicts();
      send_request(random_request());
    end
    drain_verdicts();
    repeat (8) @(posedge clk);

    if (board.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
